// ----- src/plt_pkg.sv -----
package plt_pkg;

   localparam int DATA_W = 32;
   localparam int MODE_W = 3;
   localparam int POS_W = 7;
   localparam int LEN_W = 7;
   localparam int STAT_W = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [POS_W-1:0]         found_position;
      logic signed [DATA_W-1:0] element;
      logic [LEN_W-1:0]         length;
      logic                     empty_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK,
      ST_PLACE,
      ST_DONE
   } st_type;

endpackage

// ----- src/positional_list_table_core.sv -----
// channel | signals                         | direction
// req     | req_valid, req_ready, req_word  | in
// rsp     | rsp_valid, rsp_ready, rsp_word  | out
//
// one word at a time; an insert, delete or find walks the entry ram
// one address per cycle
// get reads a single entry; clear and rejected requests skip the walk
// the result register frees the request side while a response waits
// reset clears the entry count; the entry ram needs no clearing pass
module positional_list_table_core
   import plt_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int ADDR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [ADDR_W-1:0] ONE_A = ADDR_W'(1);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_q;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              wr_en;

   st_type              state_ff, state_in;
   req_type             op_ff, op_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   start_ff, start_in;
   logic [ADDR_W-1:0]   stop_ff, stop_in;
   logic [ADDR_W-1:0]   pidx_ff, pidx_in;
   logic                issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [POS_W-1:0]    found_ff, found_in;
   logic [DATA_W-1:0]   elem_ff, elem_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [CMP_W-1:0]  pos_w;
   logic [CMP_W-1:0]  cnt_w;
   logic [CMP_W-1:0]  pos_m1;
   logic [CMP_W-1:0]  cnt_m1;
   logic              pos_zero;
   logic              ins_bad;
   logic              rd_bad;
   logic              is_full;
   logic              at_end;
   logic              match;
   logic              walk_done;
   logic              rsp_free;
   logic [CNT_W-1:0]  cnt_next;

   always_comb begin
      pos_w = CMP_W'(op_ff.position);
      cnt_w = CMP_W'(count_ff);
      pos_m1 = pos_w - CMP_W'(1);
      cnt_m1 = cnt_w - CMP_W'(1);
      pos_zero = (op_ff.position == '0);
      ins_bad = pos_zero || (pos_w > cnt_w + CMP_W'(1));
      rd_bad = pos_zero || (pos_w > cnt_w);
      is_full = (cnt_w == CMP_W'(CAPACITY));
      at_end = (pos_w == cnt_w + CMP_W'(1));
      match = pend_ff && (op_ff.mode == MODE_FIND) && (rd_q == op_ff.value);
      walk_done = pend_ff && (!issue_ff || match);
      rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            priority case (op_ff.mode)
               MODE_INSERT: begin
                  if (!ins_bad && !is_full) begin
                     state_in = at_end ? ST_PLACE : ST_WALK;
                  end
               end
               MODE_DELETE, MODE_GET: begin
                  if (!rd_bad) begin
                     state_in = ST_WALK;
                  end
               end
               MODE_FIND: begin
                  if (count_ff != '0) begin
                     state_in = ST_WALK;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = (op_ff.mode == MODE_INSERT) ? ST_PLACE : ST_DONE;
            end
         end
         ST_PLACE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in = op_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      start_in = start_ff;
      stop_in = stop_ff;
      pidx_in = pidx_ff;
      issue_in = issue_ff;
      pend_in = 1'b0;
      status_in = status_ff;
      found_in = found_ff;
      elem_in = elem_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr = idx_ff;
      wr_addr = (op_ff.mode == MODE_INSERT) ? pidx_ff + ONE_A : pidx_ff - ONE_A;
      wr_data = rd_q;
      wr_en = 1'b0;
      cnt_next = count_ff;
      req_ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_word;
            end
         end
         ST_DECODE: begin
            status_in = STAT_OK;
            found_in = '0;
            elem_in = '0;
            issue_in = 1'b1;
            start_in = pos_m1[ADDR_W-1:0];
            priority case (op_ff.mode)
               MODE_INSERT: begin
                  if (ins_bad) begin
                     status_in = STAT_BAD_POS;
                  end else if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     found_in = op_ff.position;
                     idx_in = cnt_m1[ADDR_W-1:0];
                     stop_in = pos_m1[ADDR_W-1:0];
                  end
               end
               MODE_DELETE: begin
                  if (rd_bad) begin
                     status_in = STAT_BAD_POS;
                  end else begin
                     idx_in = pos_m1[ADDR_W-1:0];
                     stop_in = cnt_m1[ADDR_W-1:0];
                  end
               end
               MODE_GET: begin
                  if (rd_bad) begin
                     status_in = STAT_BAD_POS;
                  end else begin
                     idx_in = pos_m1[ADDR_W-1:0];
                     stop_in = pos_m1[ADDR_W-1:0];
                  end
               end
               MODE_FIND: begin
                  status_in = STAT_NOT_FOUND;
                  idx_in = '0;
                  stop_in = cnt_m1[ADDR_W-1:0];
               end
               default: status_in = STAT_OK;
            endcase
         end
         ST_WALK: begin
            // read one entry per cycle, handle the entry read last cycle
            if (issue_ff) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               if (idx_ff == stop_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = (op_ff.mode == MODE_INSERT) ? idx_ff - ONE_A : idx_ff + ONE_A;
               end
            end
            if (pend_ff) begin
               priority case (op_ff.mode)
                  MODE_INSERT: wr_en = 1'b1;
                  MODE_DELETE: begin
                     if (pidx_ff == start_ff) begin
                        elem_in = rd_q;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end
                  MODE_GET: elem_in = rd_q;
                  MODE_FIND: begin
                     if (match) begin
                        status_in = STAT_OK;
                        found_in = POS_W'(pidx_ff) + POS_W'(1);
                        issue_in = 1'b0;
                        pend_in = 1'b0;
                     end
                  end
                  default: wr_en = 1'b0;
               endcase
            end
         end
         ST_PLACE: begin
            wr_en = 1'b1;
            wr_addr = start_ff;
            wr_data = op_ff.value;
         end
         ST_DONE: begin
            priority if (op_ff.mode == MODE_CLEAR) begin
               cnt_next = '0;
            end else if (op_ff.mode == MODE_INSERT && status_ff == STAT_OK) begin
               cnt_next = count_ff + CNT_W'(1);
            end else if (op_ff.mode == MODE_DELETE && status_ff == STAT_OK) begin
               cnt_next = count_ff - CNT_W'(1);
            end else begin
               cnt_next = count_ff;
            end
            if (rsp_free) begin
               count_in = cnt_next;
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.found_position = found_ff;
               rsp_in.element = elem_ff;
               rsp_in.length = LEN_W'(cnt_next);
               rsp_in.empty_res = (cnt_next == '0);
            end
         end
         default: req_ready = 1'b0;
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_word = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      idx_ff <= idx_in;
      start_ff <= start_in;
      stop_ff <= stop_in;
      pidx_ff <= pidx_in;
      status_ff <= status_in;
      found_ff <= found_in;
      elem_ff <= elem_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_WALK && issue_ff) |-> (wr_addr != rd_addr))
      else $error("shift write hits the address being read");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted word not decoded");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.empty_res == (count_ff == '0)))
      else $error("empty flag disagrees with entry count");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STAT_OK)
         |-> (rsp_ff.found_position == '0 && rsp_ff.element == '0))
      else $error("failed operation carries data");
`endif

endmodule

// ----- dv/positional_list_table_core_test.sv -----
`timescale 1ns / 1ps

module positional_list_table_core_test;
   import plt_pkg::*;

   localparam int CAPACITY = 64;
   localparam int HALF_PERIOD = 5;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 2 * CAPACITY + 16;
   localparam logic [MODE_W-1:0] MODE_LAST = '1;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC} rdy_style_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_word;

   logic signed [DATA_W-1:0] list_words [CAPACITY];
   int list_len;
   rsp_type list_outcome_q [$];

   int error_count;
   int request_count;
   int result_count;
   int peak_len;
   int full_refusals;
   int burst_left;
   bit steady;
   bit long_hold_req;
   int stall_cycles;

   positional_list_table_core #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic rsp_type list_apply(input req_type w);
      rsp_type r;
      int pos;
      int i;
      r = '0;
      r.status = STAT_OK;
      pos = w.position;
      case (w.mode)
         MODE_INSERT: begin
            if (pos == 0 || pos > list_len + 1) begin
               r.status = STAT_BAD_POS;
            end else if (list_len >= CAPACITY) begin
               r.status = STAT_FULL;
               full_refusals++;
            end else begin
               for (i = list_len; i >= pos; i--) list_words[i] = list_words[i - 1];
               list_words[pos - 1] = w.value;
               list_len++;
               r.found_position = POS_W'(pos);
            end
         end
         MODE_DELETE: begin
            if (pos == 0 || pos > list_len) begin
               r.status = STAT_BAD_POS;
            end else begin
               r.element = list_words[pos - 1];
               for (i = pos; i < list_len; i++) list_words[i - 1] = list_words[i];
               list_len--;
            end
         end
         MODE_GET: begin
            if (pos == 0 || pos > list_len) r.status = STAT_BAD_POS;
            else r.element = list_words[pos - 1];
         end
         MODE_FIND: begin
            r.status = STAT_NOT_FOUND;
            for (i = 0; i < list_len; i++) begin
               if (list_words[i] == w.value) begin
                  r.status = STAT_OK;
                  r.found_position = POS_W'(i + 1);
                  break;
               end
            end
         end
         MODE_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      r.length = LEN_W'(list_len);
      r.empty_res = (list_len == 0);
      if (list_len > peak_len) peak_len = list_len;
      return r;
   endfunction

   function automatic req_type make_req(input logic [MODE_W-1:0] m, input int pos,
                                        input logic signed [DATA_W-1:0] v);
      req_type w;
      w.mode = m;
      w.position = POS_W'(pos);
      w.value = v;
      return w;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 15))
         0: return {1'b1, {(DATA_W - 1){1'b0}}};
         1: return {1'b0, {(DATA_W - 1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // a position past the given limit, or zero
   function automatic int bad_pos(input int limit);
      if ($urandom_range(0, 3) == 0 || limit >= POS_MAX) return 0;
      return $urandom_range(limit + 1, POS_MAX);
   endfunction

   task automatic push_request(input req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      request_count++;
      list_outcome_q.push_back(list_apply(w));
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic test_edge_cases();
      logic [MODE_W-1:0] m;
      push_request(make_req(MODE_GET, 1, rand_value()));
      push_request(make_req(MODE_DELETE, 1, rand_value()));
      push_request(make_req(MODE_GET, 0, rand_value()));
      push_request(make_req(MODE_FIND, 0, '0));
      push_request(make_req(MODE_INSERT, 0, rand_value()));
      push_request(make_req(MODE_INSERT, 2, rand_value()));
      push_request(make_req(MODE_INSERT, 1, {1'b1, {(DATA_W - 1){1'b0}}}));
      push_request(make_req(MODE_INSERT, 2, {1'b0, {(DATA_W - 1){1'b1}}}));
      push_request(make_req(MODE_INSERT, 1, '1));
      push_request(make_req(MODE_INSERT, 4, '0));
      push_request(make_req(MODE_GET, 4, rand_value()));
      push_request(make_req(MODE_GET, 5, rand_value()));
      push_request(make_req(MODE_GET, POS_MAX, rand_value()));
      push_request(make_req(MODE_FIND, 0, {1'b0, {(DATA_W - 1){1'b1}}}));
      push_request(make_req(MODE_FIND, 0, 32'sd12345));
      push_request(make_req(MODE_DELETE, 4, rand_value()));
      push_request(make_req(MODE_DELETE, 1, rand_value()));
      push_request(make_req(MODE_DELETE, 3, rand_value()));
      for (m = MODE_CLEAR + MODE_W'(1); m != '0; m++) push_request(make_req(m, POS_MAX, '1));
      push_request(make_req(MODE_CLEAR, POS_MAX, rand_value()));
      push_request(make_req(MODE_GET, 1, rand_value()));
   endtask

   task automatic test_full_list();
      while (list_len < CAPACITY)
         push_request(make_req(MODE_INSERT, $urandom_range(1, list_len + 1), rand_value()));
      push_request(make_req(MODE_INSERT, CAPACITY + 1, rand_value()));
      push_request(make_req(MODE_INSERT, CAPACITY + 2, rand_value()));
      push_request(make_req(MODE_INSERT, 1, rand_value()));
      push_request(make_req(MODE_GET, CAPACITY, rand_value()));
      push_request(make_req(MODE_GET, CAPACITY + 1, rand_value()));
      push_request(make_req(MODE_FIND, 0, list_words[CAPACITY - 1]));
      push_request(make_req(MODE_DELETE, CAPACITY, rand_value()));
      push_request(make_req(MODE_INSERT, CAPACITY, rand_value()));
      push_request(make_req(MODE_DELETE, 1, rand_value()));
      push_request(make_req(MODE_CLEAR, 0, rand_value()));
   endtask

   task automatic test_random_ops(input int count);
      int n;
      int grow_bias;
      int pick;
      logic [MODE_W-1:0] m;
      logic signed [DATA_W-1:0] v;
      grow_bias = 50;
      for (n = 0; n < count; n++) begin
         if (n % 150 == 0) grow_bias = $urandom_range(15, 85);
         steady = (n % 400) < 60;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            push_request(make_req(MODE_W'($urandom_range(0, MODE_LAST)),
                                  $urandom_range(0, POS_MAX), $urandom));
         end else if (pick < 6) begin
            push_request(make_req(MODE_CLEAR, $urandom_range(0, POS_MAX), $urandom));
         end else if ($urandom_range(0, 99) < grow_bias) begin
            if ($urandom_range(0, 9) == 0)
               push_request(make_req(MODE_INSERT, bad_pos(list_len + 1), rand_value()));
            else
               push_request(make_req(MODE_INSERT, $urandom_range(1, list_len + 1),
                                     rand_value()));
         end else begin
            case ($urandom_range(0, 2))
               0: m = MODE_DELETE;
               1: m = MODE_GET;
               default: m = MODE_FIND;
            endcase
            if (m == MODE_FIND) begin
               v = rand_value();
               if (list_len > 0 && $urandom_range(0, 9) < 6)
                  v = list_words[$urandom_range(0, list_len - 1)];
               push_request(make_req(m, $urandom_range(0, POS_MAX), v));
            end else if (list_len == 0 || $urandom_range(0, 9) == 0) begin
               push_request(make_req(m, bad_pos(list_len), rand_value()));
            end else begin
               push_request(make_req(m, $urandom_range(1, list_len), rand_value()));
            end
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      int n;
      steady = 1'b1;
      long_hold_req = 1'b1;
      for (n = 0; n < 30; n++) begin
         if (n % 3 == 0) push_request(make_req(MODE_INSERT, 1, rand_value()));
         else push_request(make_req(MODE_GET, $urandom_range(0, list_len + 1), rand_value()));
      end
      steady = 1'b0;
   endtask

   initial begin : rsp_stall
      int phase_len;
      int period;
      int n;
      rdy_style_type style;
      rsp_ready = 1'b0;
      forever begin
         phase_len = $urandom_range(16, 160);
         period = $urandom_range(2, 5);
         style = rdy_style_type'($urandom_range(RDY_ALWAYS, RDY_PERIODIC));
         for (n = 0; n < phase_len; n++) begin
            @(negedge clock);
            if (long_hold_req) begin
               rsp_ready <= 1'b0;
               repeat (LONG_HOLD_CYCLES) @(negedge clock);
               long_hold_req = 1'b0;
            end
            case (style)
               RDY_ALWAYS: rsp_ready <= 1'b1;
               RDY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ((n % period) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (list_outcome_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_word);
            error_count++;
         end else begin
            want = list_outcome_q.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_word.status));
            check_field("found_position", DATA_W'(want.found_position),
                        DATA_W'(rsp_word.found_position));
            check_field("element", want.element, rsp_word.element);
            check_field("length", DATA_W'(want.length), DATA_W'(rsp_word.length));
            check_field("empty_res", DATA_W'(want.empty_res), DATA_W'(rsp_word.empty_res));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      list_len = 0;
      error_count = 0;
      request_count = 0;
      result_count = 0;
      peak_len = 0;
      full_refusals = 0;
      burst_left = 0;
      steady = 1'b0;
      long_hold_req = 1'b0;
      stall_cycles = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_full_list();
      test_random_ops(1230);
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (list_outcome_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (list_outcome_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, list_outcome_q.size());
         error_count++;
      end

      $display("%0d requests over all five operations and spare modes, %0d results checked",
               request_count, result_count);
      $display("list grew to %0d entries, %0d inserts refused as full, %0d mismatches",
               peak_len, full_refusals, error_count);
      if (error_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
